// ===== design/wtd_pkg.sv =====
// Shared widths, codes and payload types of the weighted table draw block.
package wtd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned DRAW_W      = 31;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [DRAW_W-1:0]     t_draw;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ENTRIES_IN_USE = 1'b0;
    localparam t_cfg_idx CFG_MODULUS        = 1'b1;

endpackage

// ===== design/wtd_cmd_if.sv =====
// Command channel: table writes and draw requests.
interface wtd_cmd_if;
    logic            valid;
    logic            ready;
    logic            command;
    wtd_pkg::t_slot  entry_index;
    wtd_pkg::t_word  entry_value;
    wtd_pkg::t_word  entry_weight;
    wtd_pkg::t_draw  random_draw;

    modport source (output valid, output command, output entry_index,
                    output entry_value, output entry_weight, output random_draw,
                    input ready);
    modport sink   (input valid, input command, input entry_index,
                    input entry_value, input entry_weight, input random_draw,
                    output ready);
endinterface

// ===== design/wtd_res_if.sv =====
// Result channel: chosen value of a draw.
interface wtd_res_if;
    logic            valid;
    logic            ready;
    wtd_pkg::t_word  chosen_value;

    modport source (output valid, output chosen_value, input ready);
    modport sink   (input valid, input chosen_value, output ready);
endinterface

// ===== design/wtd_cfg_if.sv =====
// Configuration write channel.
interface wtd_cfg_if;
    logic                valid;
    logic                ready;
    wtd_pkg::t_cfg_idx   reg_index;
    wtd_pkg::t_cfg_data  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== design/wtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wtd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/weighted_table_draw.sv =====
// Top level of the weighted table draw block: table, modulo reduction and scan.
//
// The block holds TABLE_DEPTH (value, weight) pairs in one RAM. A write command
// stores a pair and gives no result; a slot at or beyond TABLE_DEPTH is
// dropped. A draw command reduces random_draw modulo the configured modulus
// with a restoring divider that retires one quotient bit a cycle (skipped
// when the modulus is zero), then scans entries 0 .. N-1 one per cycle
// through the RAM read port, where N is entries_in_use clamped to
// 1 .. TABLE_DEPTH. One subtractor serves both the divider and the scan. The
// first entry whose weight exceeds the running remainder is chosen; if none
// does, entry N-1 is chosen. After the scan the choice waits in the hold state
// while the previous result still sits in the output register; the command
// channel is not ready while a draw is in flight. The result sits in an output
// register, so writes are taken while an earlier result waits. Configuration
// is always ready and must be written only while the block is idle. Entries
// that were never written read as unknown data.
module weighted_table_draw #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtd_cmd_if.sink     i_cmd,
    wtd_res_if.source   o_res,
    wtd_cfg_if.sink     i_cfg
);

    localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned IW   = (AW > wtd_pkg::SLOT_W) ? AW : wtd_pkg::SLOT_W;
    localparam int unsigned NW0  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NW   = (NW0 > wtd_pkg::COUNT_W) ? NW0 : wtd_pkg::COUNT_W;
    localparam int unsigned WW   = wtd_pkg::WORD_W;
    localparam int unsigned DW   = wtd_pkg::DRAW_W;
    localparam int unsigned CNTW = $clog2(DW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // Control state
    logic [1:0]           r_state, n_state;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]        r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    wtd_pkg::t_count      r_entries_in_use;
    wtd_pkg::t_word       r_modulus;

    // Datapath
    wtd_pkg::t_word       r_rem, n_rem;
    wtd_pkg::t_draw       r_dvd, n_dvd;
    logic [AW-1:0]        r_last, n_last;
    wtd_pkg::t_word       r_pick, n_pick;
    wtd_pkg::t_word       r_out_data, n_out_data;

    logic                 cmd_fire;
    logic                 cfg_fire;
    logic                 slot_ok;
    logic [IW-1:0]        slot_ext;
    logic [NW-1:0]        use_ext;
    logic [NW-1:0]        use_clamp;
    logic [WW:0]          trial;
    logic [WW:0]          sub_a;
    logic [WW:0]          sub_b;
    logic [WW:0]          diff;
    logic [2*WW-1:0]      wr_word;
    logic [2*WW-1:0]      rd_word;
    wtd_pkg::t_word       rd_value;
    wtd_pkg::t_word       rd_weight;
    logic                 out_free;

    assign cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_out_valid;
    assign o_res.chosen_value = r_out_data;
    assign out_free = !r_out_valid || o_res.ready;

    // Table write: drop slots beyond the table
    assign slot_ext = IW'(i_cmd.entry_index);
    assign slot_ok  = (32'(i_cmd.entry_index) < 32'(TABLE_DEPTH));
    assign wr_word  = {i_cmd.entry_weight, i_cmd.entry_value};

    wtd_ram #(
        .WIDTH (2 * WW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (cmd_fire && (i_cmd.command == wtd_pkg::CMD_WRITE) && slot_ok),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata (wr_word),
        .i_raddr (n_idx),
        .o_rdata (rd_word)
    );

    assign rd_value  = rd_word[WW-1:0];
    assign rd_weight = rd_word[2*WW-1:WW];

    // Scan length: clamp entries_in_use to 1 .. TABLE_DEPTH
    always_comb begin
        use_ext = NW'(r_entries_in_use);
        if (use_ext == '0) begin
            use_clamp = NW'(1);
        end else if (32'(use_ext) > 32'(TABLE_DEPTH)) begin
            use_clamp = NW'(TABLE_DEPTH);
        end else begin
            use_clamp = use_ext;
        end
    end

    // Shared subtractor. Divide: shift in the next dividend bit and trial the
    // modulus. Scan: take the entry weight off the remainder; the borrow bit
    // flags a remainder below the weight.
    assign trial = {r_rem, r_dvd[DW-1]};
    assign sub_a = (r_state == ST_DIV) ? trial : {1'b0, r_rem};
    assign sub_b = {1'b0, (r_state == ST_DIV) ? r_modulus : rd_weight};
    assign diff  = sub_a - sub_b;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = '0;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_last      = r_last;
        n_pick      = r_pick;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire && (i_cmd.command == wtd_pkg::CMD_DRAW)) begin
                    n_last = AW'(use_clamp - NW'(1));
                    n_cnt  = '0;
                    if (r_modulus == '0) begin
                        // No reduction: scan with the raw draw
                        n_rem   = WW'(i_cmd.random_draw);
                        n_state = ST_SCAN;
                    end else begin
                        n_rem   = '0;
                        n_dvd   = i_cmd.random_draw;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = diff[WW] ? trial[WW-1:0] : diff[WW-1:0];
                n_dvd = {r_dvd[DW-2:0], 1'b0};
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_word holds entry r_idx
                if (diff[WW]) begin
                    n_pick  = rd_value;
                    n_state = ST_HOLD;
                end else begin
                    n_rem = diff[WW-1:0];
                    if (r_idx == r_last) begin
                        n_pick  = rd_value;
                        n_state = ST_HOLD;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pick;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_cnt            <= '0;
            r_idx            <= '0;
            r_out_valid      <= 1'b0;
            r_entries_in_use <= wtd_pkg::t_count'(1);
            r_modulus        <= wtd_pkg::t_word'(1);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (cfg_fire) begin
                unique case (i_cfg.reg_index)
                    wtd_pkg::CFG_ENTRIES_IN_USE: begin
                        r_entries_in_use <= i_cfg.wr_data[wtd_pkg::COUNT_W-1:0];
                    end
                    wtd_pkg::CFG_MODULUS: begin
                        r_modulus <= i_cfg.wr_data[WW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_last     <= n_last;
        r_pick     <= n_pick;
        r_out_data <= n_out_data;
    end

    // The partial remainder stays below the modulus while dividing
    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_modulus))
        else $error("partial remainder not below the modulus");

    // The scan never passes the last entry in use
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_last))
        else $error("scan index beyond last entry in use");

    // An accepted draw starts dividing or scanning at once
    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_fire && (i_cmd.command == wtd_pkg::CMD_DRAW))
        |=> ((r_state == ST_DIV) || (r_state == ST_SCAN)))
        else $error("accepted draw did not start");

    // A held result only waits on a full output register
    a_hold_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && $past(r_state == ST_HOLD)) |-> $past(r_out_valid))
        else $error("result held without a pending output");

    // A write command leaves the block idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_fire && (i_cmd.command == wtd_pkg::CMD_WRITE)) |=> (r_state == ST_IDLE))
        else $error("write command left the idle state");

endmodule
